// ===== hw/rtl/slkf_pkg.sv =====
// Shared types and codes for the session keep-alive client.
// No dependencies; imported by every module of the block.
`default_nettype none

package slkf_pkg;

	localparam int RES_MAX = 5;
	localparam int CNT_W   = 3;

	localparam logic [2:0] PH_IDLE      = 3'd1;
	localparam logic [2:0] PH_CONNECT   = 3'd2;
	localparam logic [2:0] PH_ONLINE    = 3'd3;
	localparam logic [2:0] PH_DISCONN   = 3'd4;
	localparam logic [2:0] PH_CLOSED    = 3'd5;

	localparam logic [1:0] REQ_NONE       = 2'd0;
	localparam logic [1:0] REQ_CONNECT    = 2'd1;
	localparam logic [1:0] REQ_DISCONNECT = 2'd2;

	localparam logic [2:0] RX_CONN_SYN_ACK    = 3'd0;
	localparam logic [2:0] RX_ALIVE_SYN       = 3'd1;
	localparam logic [2:0] RX_DISCONN_SYN_ACK = 3'd2;
	localparam logic [2:0] RX_FIN             = 3'd3;
	localparam logic [2:0] RX_ERROR           = 3'd4;

	localparam logic [1:0] EV_PACKET  = 2'd0;
	localparam logic [1:0] EV_STATUS  = 2'd1;
	localparam logic [1:0] EV_ERROR   = 2'd2;
	localparam logic [1:0] EV_SUMMARY = 2'd3;

	localparam logic [2:0] PK_CONN_SYN    = 3'd0;
	localparam logic [2:0] PK_CONN_ACK    = 3'd1;
	localparam logic [2:0] PK_ALIVE_ACK   = 3'd2;
	localparam logic [2:0] PK_DISCONN_SYN = 3'd3;
	localparam logic [2:0] PK_DISCONN_ACK = 3'd4;

	localparam logic [15:0] SESSION_TO_RST = 16'd60;
	localparam logic [15:0] ALIVE_TO_RST   = 16'd5;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        rx_valid;
		logic [2:0]  rx_type;
		logic [31:0] rx_seq;
		logic [15:0] rx_user_timeout;
		logic [15:0] rx_alive_timeout;
		logic        second_tick;
	} item_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  pending;
		logic [15:0] elapsed;
		logic [31:0] seq;
		logic [15:0] session_to;
		logic [15:0] alive_to;
		logic        first_connect;
	} sess_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [2:0]  pkt_kind;
		logic [31:0] seq_sent;
		logic        online;
		logic [2:0]  phase_now;
		logic        last;
	} rec_t;

	typedef struct packed {
		rec_t [RES_MAX-1:0] rec;
		logic [CNT_W-1:0]   cnt;
	} rec_list_t;

endpackage

`default_nettype wire

// ===== hw/rtl/session_link_keepalive_fsm.sv =====
// Session keep-alive client top level: input register, session state, result buffer.
// Depends on slkf_pkg, slkf_pass and slkf_outq.
//
// Use: each input transaction (cmd, rx_* fields, second_tick) is one pass of the
// session client. It yields one to four result transactions: the packets sent,
// status changes and server errors in order, then a summary with last set.
// auto_reconnect is written through cfg_wen/cfg_wdata; the user writes it only while
// the block is idle, and the block itself does not enforce this. An item is
// registered in the input register on acceptance; once the result buffer is free,
// its pass is evaluated and the session state and record list are loaded into the
// result buffer, from which its first result is offered.
// The result buffer drains one record per cycle while out_stall is low, and the
// input register takes the next item while it drains.
// Reset: phase 1, no pending request, timeouts 60 s and 5 s, sequence 0,
// first-connect set, auto_reconnect clear, both buffers empty.
// Output stall holds the current record; while the input register is full and the
// buffer is not free, in_stall is high.
`default_nettype none

module session_link_keepalive_fsm (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wen,
	input  wire         cfg_wdata,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  cmd,
	input  wire         rx_valid,
	input  wire  [2:0]  rx_type,
	input  wire  [31:0] rx_seq,
	input  wire  [15:0] rx_user_timeout,
	input  wire  [15:0] rx_alive_timeout,
	input  wire         second_tick,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  event_kind,
	output logic [2:0]  pkt_kind,
	output logic [31:0] seq_sent,
	output logic        online,
	output logic [2:0]  phase_now,
	output logic        last
);
	import slkf_pkg::*;

	item_t     item_s1;
	logic      valid_s1;
	sess_t     st_q;
	sess_t     st_next;
	logic      auto_q;
	rec_list_t list;
	rec_t      head;
	logic      free;
	logic      adv;
	logic      accept;

	assign adv      = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q <= 1'b0;
		end else if (cfg_wen) begin
			auto_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd              <= cmd;
			item_s1.rx_valid         <= rx_valid;
			item_s1.rx_type          <= rx_type;
			item_s1.rx_seq           <= rx_seq;
			item_s1.rx_user_timeout  <= rx_user_timeout;
			item_s1.rx_alive_timeout <= rx_alive_timeout;
			item_s1.second_tick      <= second_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= PH_IDLE;
			st_q.pending       <= REQ_NONE;
			st_q.elapsed       <= '0;
			st_q.seq           <= '0;
			st_q.session_to    <= SESSION_TO_RST;
			st_q.alive_to      <= ALIVE_TO_RST;
			st_q.first_connect <= 1'b1;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	slkf_pass u_pass (
		.item           (item_s1),
		.st             (st_q),
		.auto_reconnect (auto_q),
		.st_next        (st_next),
		.list           (list)
	);

	slkf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.list      (list),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign event_kind = head.event_kind;
	assign pkt_kind   = head.pkt_kind;
	assign seq_sent   = head.seq_sent;
	assign online     = head.online;
	assign phase_now  = head.phase_now;
	assign last       = head.last;

	a_adv_shows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("pass loaded but no result offered");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid))
		else $error("input stalled with nothing held");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IDLE) || (st_q.phase == PH_CONNECT) || (st_q.phase == PH_ONLINE)
		|| (st_q.phase == PH_DISCONN) || (st_q.phase == PH_CLOSED))
		else $error("session phase out of range");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st_q))
		else $error("session state changed without a pass");

endmodule

`default_nettype wire

// ===== hw/rtl/slkf_pass.sv =====
// One session pass: next session state and the ordered list of result records.
// Depends on slkf_pkg.
`default_nettype none

module slkf_pass (
	input  wire slkf_pkg::item_t     item,
	input  wire slkf_pkg::sess_t     st,
	input  wire                      auto_reconnect,
	output slkf_pkg::sess_t          st_next,
	output slkf_pkg::rec_list_t      list
);
	import slkf_pkg::*;

	sess_t            ns;
	rec_list_t        ls;
	logic [CNT_W-1:0] n;

	function automatic rec_t mk_rec(input logic [1:0] kind, input logic [2:0] pkt,
			input logic [31:0] seq, input logic on, input logic [2:0] ph,
			input logic lst);
		rec_t r;
		r.event_kind = kind;
		r.pkt_kind   = pkt;
		r.seq_sent   = seq;
		r.online     = on;
		r.phase_now  = ph;
		r.last       = lst;
		return r;
	endfunction

	always_comb begin
		ns = st;
		ls = '0;
		n  = '0;

		if (item.second_tick && (ns.elapsed != 16'hFFFF)) begin
			ns.elapsed = ns.elapsed + 16'd1;
		end

		if (item.cmd == REQ_CONNECT) begin
			ns.pending = REQ_CONNECT;
		end else if (item.cmd == REQ_DISCONNECT) begin
			ns.pending       = REQ_DISCONNECT;
			ns.first_connect = 1'b1;
		end

		if (item.rx_valid) begin
			case (item.rx_type)
				RX_CONN_SYN_ACK: begin
					ns.session_to = item.rx_user_timeout;
					ns.alive_to   = item.rx_alive_timeout;
					ns.seq        = item.rx_seq + 32'd1;
					ns.phase      = PH_ONLINE;
					ns.elapsed    = '0;
					ls.rec[n] = mk_rec(EV_PACKET, PK_CONN_ACK, ns.seq, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
				RX_ALIVE_SYN: begin
					ls.rec[n] = mk_rec(EV_STATUS, PK_CONN_SYN, '0, 1'b1, ns.phase, 1'b0);
					n = n + 1'b1;
					ns.seq = item.rx_seq + 32'd1;
					ls.rec[n] = mk_rec(EV_PACKET, PK_ALIVE_ACK, ns.seq, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
					ns.elapsed = '0;
				end
				RX_DISCONN_SYN_ACK: begin
					ns.seq     = item.rx_seq;
					ns.phase   = PH_CLOSED;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_PACKET, PK_DISCONN_ACK, item.rx_seq + 32'd1,
						1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
				RX_FIN: begin
					ns.phase   = PH_IDLE;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_STATUS, PK_CONN_SYN, '0, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
				RX_ERROR: begin
					ns.phase   = PH_IDLE;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_ERROR, PK_CONN_SYN, '0, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
				default: begin
				end
			endcase
		end

		case (ns.phase)
			PH_IDLE: begin
				if (ns.pending == REQ_CONNECT) begin
					ns.pending = REQ_NONE;
					ns.phase   = PH_CONNECT;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_PACKET, PK_CONN_SYN, '0, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
				if (auto_reconnect && !ns.first_connect) begin
					ns.pending = REQ_CONNECT;
				end
			end
			PH_CONNECT, PH_ONLINE: begin
				if ((ns.phase == PH_CONNECT) ? (ns.elapsed > ns.alive_to)
						: (ns.elapsed > ns.session_to)) begin
					if (ns.phase == PH_ONLINE) begin
						ns.first_connect = 1'b0;
					end
					ns.phase   = PH_IDLE;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_STATUS, PK_CONN_SYN, '0, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
				if (ns.pending == REQ_DISCONNECT) begin
					ns.pending = REQ_NONE;
					ns.phase   = PH_DISCONN;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_PACKET, PK_DISCONN_SYN, '0, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
			end
			PH_DISCONN, PH_CLOSED: begin
				if (ns.elapsed > ns.alive_to) begin
					ns.phase   = PH_IDLE;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_STATUS, PK_CONN_SYN, '0, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
				if (ns.pending == REQ_CONNECT) begin
					ns.pending = REQ_NONE;
					ns.phase   = PH_CONNECT;
					ns.elapsed = '0;
					ls.rec[n] = mk_rec(EV_PACKET, PK_CONN_SYN, '0, 1'b0, ns.phase, 1'b0);
					n = n + 1'b1;
				end
			end
			default: begin
				ns.phase   = PH_IDLE;
				ns.elapsed = '0;
			end
		endcase

		ls.rec[n] = mk_rec(EV_SUMMARY, PK_CONN_SYN, ns.seq, 1'b0, ns.phase, 1'b1);
		ls.cnt    = n + 1'b1;
	end

	assign st_next = ns;
	assign list    = ls;

endmodule

`default_nettype wire

// ===== hw/rtl/slkf_outq.sv =====
// Result buffer: holds the record list of one pass and shifts it out one per transaction.
// Depends on slkf_pkg.
`default_nettype none

module slkf_outq (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire slkf_pkg::rec_list_t  list,
	output logic                      free,
	output logic                      out_valid,
	input  wire                       out_stall,
	output slkf_pkg::rec_t            head
);
	import slkf_pkg::*;

	rec_t [RES_MAX-1:0] rec_s2;
	logic [CNT_W-1:0]   cnt_s2;
	logic               pop;

	assign out_valid = (cnt_s2 != '0);
	assign pop       = out_valid && !out_stall;
	assign free      = (cnt_s2 == '0) || (pop && (cnt_s2 == CNT_W'(1)));
	assign head      = rec_s2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (push) begin
			cnt_s2 <= list.cnt;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rec_s2 <= list.rec;
		end else if (pop) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				rec_s2[i] <= rec_s2[i+1];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 <= CNT_W'(RES_MAX))
		else $error("result count beyond buffer depth");

	a_last_at_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (head.last == (cnt_s2 == CNT_W'(1))))
		else $error("summary record not at the tail of the pass");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> free)
		else $error("pass loaded while records still pending");

	a_push_load: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cnt_s2 == $past(list.cnt)))
		else $error("record count not loaded");

endmodule

`default_nettype wire

// ===== verif/session_link_keepalive_fsm_test.sv =====
// Testbench for session_link_keepalive_fsm: directed and random session traffic,
// each pass predicted in-bench and every result transaction checked in order.
// Depends on slkf_pkg and the session_link_keepalive_fsm RTL.
`default_nettype none

module session_link_keepalive_fsm_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slkf_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_TICKS  = 6;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic        rx_valid;
	logic [2:0]  rx_type;
	logic [31:0] rx_seq;
	logic [15:0] rx_user_timeout;
	logic [15:0] rx_alive_timeout;
	logic        second_tick;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [2:0]  pkt_kind;
	logic [31:0] seq_sent;
	logic        online;
	logic [2:0]  phase_now;
	logic        last;

	logic [2:0]  sess_phase;
	logic [1:0]  sess_pending;
	logic [15:0] sess_elapsed;
	logic [31:0] sess_seq;
	logic [15:0] sess_to_user;
	logic [15:0] sess_to_alive;
	logic        sess_first;
	logic        cfg_auto;

	rec_t expected_recs[$];
	int   pass_recs;
	int   passes_sent;
	int   recs_checked = 0;
	int   fail_count = 0;
	int   cycles = 0;
	int   stall_left = 0;
	bit   src_quiet;
	bit   sink_quiet;

	session_link_keepalive_fsm dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.rx_valid         (rx_valid),
		.rx_type          (rx_type),
		.rx_seq           (rx_seq),
		.rx_user_timeout  (rx_user_timeout),
		.rx_alive_timeout (rx_alive_timeout),
		.second_tick      (second_tick),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_kind       (event_kind),
		.pkt_kind         (pkt_kind),
		.seq_sent         (seq_sent),
		.online           (online),
		.phase_now        (phase_now),
		.last             (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
		fail_count++;
	endtask

	task automatic push_rec(input logic [1:0] kind, input logic [2:0] pkt,
			input logic [31:0] seq, input logic on, input logic lst);
		rec_t r;
		if (pass_recs < RES_MAX) begin
			r.event_kind = kind;
			r.pkt_kind   = pkt;
			r.seq_sent   = seq;
			r.online     = on;
			r.phase_now  = sess_phase;
			r.last       = lst;
			expected_recs.insert(expected_recs.size(), r);
			pass_recs++;
		end
	endtask

	task automatic move_to(input logic [2:0] p);
		sess_phase   = p;
		sess_elapsed = '0;
	endtask

	task automatic go_offline();
		move_to(PH_IDLE);
		push_rec(EV_STATUS, PK_CONN_SYN, '0, 1'b0, 1'b0);
	endtask

	task automatic send_conn_if_pending();
		if (sess_pending == REQ_CONNECT) begin
			sess_pending = REQ_NONE;
			move_to(PH_CONNECT);
			push_rec(EV_PACKET, PK_CONN_SYN, '0, 1'b0, 1'b0);
		end
	endtask

	task automatic send_disconn_if_pending();
		if (sess_pending == REQ_DISCONNECT) begin
			sess_pending = REQ_NONE;
			move_to(PH_DISCONN);
			push_rec(EV_PACKET, PK_DISCONN_SYN, '0, 1'b0, 1'b0);
		end
	endtask

	task automatic reset_session();
		sess_phase    = PH_IDLE;
		sess_pending  = REQ_NONE;
		sess_elapsed  = '0;
		sess_seq      = '0;
		sess_to_user  = SESSION_TO_RST;
		sess_to_alive = ALIVE_TO_RST;
		sess_first    = 1'b1;
		cfg_auto      = 1'b0;
	endtask

	task automatic advance_session(input item_t it);
		pass_recs = 0;
		if (it.second_tick && sess_elapsed != 16'hFFFF)
			sess_elapsed = sess_elapsed + 16'd1;
		if (it.cmd == REQ_CONNECT) begin
			sess_pending = REQ_CONNECT;
		end else if (it.cmd == REQ_DISCONNECT) begin
			sess_pending = REQ_DISCONNECT;
			sess_first   = 1'b1;
		end
		if (it.rx_valid) begin
			case (it.rx_type)
				RX_CONN_SYN_ACK: begin
					sess_to_user  = it.rx_user_timeout;
					sess_to_alive = it.rx_alive_timeout;
					sess_seq      = it.rx_seq + 32'd1;
					move_to(PH_ONLINE);
					push_rec(EV_PACKET, PK_CONN_ACK, sess_seq, 1'b0, 1'b0);
				end
				RX_ALIVE_SYN: begin
					push_rec(EV_STATUS, PK_CONN_SYN, '0, 1'b1, 1'b0);
					sess_seq = it.rx_seq + 32'd1;
					push_rec(EV_PACKET, PK_ALIVE_ACK, sess_seq, 1'b0, 1'b0);
					sess_elapsed = '0;
				end
				RX_DISCONN_SYN_ACK: begin
					sess_seq = it.rx_seq;
					move_to(PH_CLOSED);
					push_rec(EV_PACKET, PK_DISCONN_ACK, it.rx_seq + 32'd1, 1'b0, 1'b0);
				end
				RX_FIN: begin
					go_offline();
				end
				RX_ERROR: begin
					move_to(PH_IDLE);
					push_rec(EV_ERROR, PK_CONN_SYN, '0, 1'b0, 1'b0);
				end
				default: begin
				end
			endcase
		end
		case (sess_phase)
			PH_IDLE: begin
				send_conn_if_pending();
				if (cfg_auto && !sess_first)
					sess_pending = REQ_CONNECT;
			end
			PH_CONNECT: begin
				if (sess_elapsed > sess_to_alive)
					go_offline();
				send_disconn_if_pending();
			end
			PH_ONLINE: begin
				if (sess_elapsed > sess_to_user) begin
					go_offline();
					sess_first = 1'b0;
				end
				send_disconn_if_pending();
			end
			PH_DISCONN, PH_CLOSED: begin
				if (sess_elapsed > sess_to_alive)
					go_offline();
				send_conn_if_pending();
			end
			default: begin
				move_to(PH_IDLE);
			end
		endcase
		push_rec(EV_SUMMARY, PK_CONN_SYN, sess_seq, 1'b0, 1'b1);
	endtask

	function automatic item_t mk_item(input logic [1:0] c, input logic v, input logic [2:0] t,
			input logic [31:0] s, input logic [15:0] ut, input logic [15:0] at,
			input logic tick);
		item_t it;
		it.cmd              = c;
		it.rx_valid         = v;
		it.rx_type          = t;
		it.rx_seq           = s;
		it.rx_user_timeout  = ut;
		it.rx_alive_timeout = at;
		it.second_tick      = tick;
		return it;
	endfunction

	task automatic send_pass(input item_t it);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		cmd              <= it.cmd;
		rx_valid         <= it.rx_valid;
		rx_type          <= it.rx_type;
		rx_seq           <= it.rx_seq;
		rx_user_timeout  <= it.rx_user_timeout;
		rx_alive_timeout <= it.rx_alive_timeout;
		second_tick      <= it.second_tick;
		do @(posedge clk); while (in_stall);
		advance_session(it);
		passes_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_recs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_auto_reconnect(input logic v);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		cfg_auto  = v;
	endtask

	always @(posedge clk) begin
		rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			recs_checked++;
			if (expected_recs.size() == 0) begin
				report_mismatch("unexpected result, kind", 32'(event_kind), '0);
			end else begin
				want = expected_recs.pop_front();
				if (event_kind !== want.event_kind)
					report_mismatch("event_kind", 32'(event_kind), 32'(want.event_kind));
				if (pkt_kind !== want.pkt_kind)
					report_mismatch("pkt_kind", 32'(pkt_kind), 32'(want.pkt_kind));
				if (seq_sent !== want.seq_sent)
					report_mismatch("seq_sent", seq_sent, want.seq_sent);
				if (online !== want.online)
					report_mismatch("online", 32'(online), 32'(want.online));
				if (phase_now !== want.phase_now)
					report_mismatch("phase_now", 32'(phase_now), 32'(want.phase_now));
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
			end
			stall_left = sink_quiet ? 0 : $urandom_range(0, 6);
		end
		if (arst_n && stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic item_t next_random_pass();
		item_t it;
		int    pick;
		it = mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, $urandom(),
			16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			it.cmd              = 2'($urandom_range(0, 3));
			it.rx_valid         = 1'($urandom_range(0, 1));
			it.rx_type          = 3'($urandom_range(0, 7));
			it.rx_user_timeout  = 16'($urandom());
			it.rx_alive_timeout = 16'($urandom());
		end else begin
			case (sess_phase)
				PH_IDLE: begin
					if (pick < 7)
						it.cmd = REQ_CONNECT;
				end
				PH_CONNECT: begin
					if (pick < 8)
						it.rx_valid = 1'b1;
					if (pick == 2) begin
						it.rx_user_timeout  = 16'($urandom());
						it.rx_alive_timeout = 16'($urandom());
					end
				end
				PH_ONLINE: begin
					if (pick < 6) begin
						it.rx_valid = 1'b1;
						it.rx_type  = RX_ALIVE_SYN;
					end else if (pick < 8) begin
						it.cmd = REQ_DISCONNECT;
					end else if (pick == 8) begin
						it.rx_valid = 1'b1;
						it.rx_type  = RX_ERROR;
					end
				end
				PH_DISCONN: begin
					if (pick < 7) begin
						it.rx_valid = 1'b1;
						it.rx_type  = RX_DISCONN_SYN_ACK;
					end
				end
				default: begin
					if (pick < 5) begin
						it.cmd = REQ_CONNECT;
					end else if (pick == 5) begin
						it.rx_valid = 1'b1;
						it.rx_type  = RX_FIN;
					end
				end
			endcase
		end
		return it;
	endfunction

	task automatic test_idle_and_ignored();
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(2'd3, 1'b1, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1));
	endtask

	task automatic test_session_walk();
		send_pass(mk_item(REQ_CONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, RX_CONN_SYN_ACK, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, RX_ALIVE_SYN, 32'hFFFF_FFFF, '0, '0, 1'b1));
		send_pass(mk_item(REQ_NONE, 1'b1, 3'd5, 32'h1234_5678, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, 3'd6, 32'h8765_4321, '0, '0, 1'b1));
		send_pass(mk_item(REQ_DISCONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, RX_DISCONN_SYN_ACK, 32'hFFFF_FFFF, '0, '0, 1'b0));
		send_pass(mk_item(REQ_CONNECT, 1'b1, RX_FIN, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, RX_ERROR, '0, '0, '0, 1'b1));
	endtask

	task automatic test_timeouts();
		send_pass(mk_item(REQ_CONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, RX_CONN_SYN_ACK, '0, 16'd0, 16'd1, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_CONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_CONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_DISCONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
	endtask

	task automatic test_auto_reconnect();
		set_auto_reconnect(1'b1);
		send_pass(mk_item(REQ_CONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, RX_CONN_SYN_ACK, 32'h0000_00FF, 16'd0, 16'd3, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_DISCONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		set_auto_reconnect(1'b0);
	endtask

	task automatic test_long_hold();
		src_quiet  = 1'b1;
		sink_quiet = 1'b1;
		send_pass(mk_item(REQ_CONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b0));
		send_pass(mk_item(REQ_NONE, 1'b1, RX_CONN_SYN_ACK, 32'h7FFF_FFFF,
			16'hFFFF, 16'd0, 1'b0));
		repeat (HOLD_TICKS)
			send_pass(mk_item(REQ_NONE, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		send_pass(mk_item(REQ_DISCONNECT, 1'b0, RX_CONN_SYN_ACK, '0, '0, '0, 1'b1));
		src_quiet  = 1'b0;
		sink_quiet = 1'b0;
	endtask

	task automatic test_random_sessions(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0) begin
				src_quiet  = ($urandom_range(0, 3) == 0);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			send_pass(next_random_pass());
		end
		src_quiet  = 1'b0;
		sink_quiet = 1'b0;
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_wen          = 1'b0;
		cfg_wdata        = 1'b0;
		in_valid         = 1'b0;
		cmd              = '0;
		rx_valid         = 1'b0;
		rx_type          = '0;
		rx_seq           = '0;
		rx_user_timeout  = '0;
		rx_alive_timeout = '0;
		second_tick      = 1'b0;
		src_quiet        = 1'b0;
		sink_quiet       = 1'b0;
		passes_sent      = 0;
		reset_session();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_auto_reconnect(1'b0);
		test_idle_and_ignored();
		test_session_walk();
		test_timeouts();
		test_auto_reconnect();
		test_long_hold();
		set_auto_reconnect(1'b0);
		test_random_sessions(40);
		set_auto_reconnect(1'b1);
		test_random_sessions(40);
		drain_results();

		$display("covered %0d passes and %0d result transactions, %0d mismatches",
			passes_sent, recs_checked, fail_count);
		$display("connect, keep-alive, disconnect, timeouts, auto-reconnect, long online hold");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== session_link_keepalive_fsm.f =====
hw/rtl/slkf_pkg.sv
hw/rtl/slkf_pass.sv
hw/rtl/slkf_outq.sv
hw/rtl/session_link_keepalive_fsm.sv
verif/session_link_keepalive_fsm_test.sv
